@@ rtl/core/gbd_pkg.sv @@
// Shared types and constants for the grid breadth-first distance unit.
// Used by gbd_ctrl, gbd_datapath and grid_bfs_distance_unit; no dependencies.
package gbd_pkg;

  // Default store dimensions
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field and register widths
  localparam int DIST_W = 12;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RST = 7'd64;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  // Neighbor order: east, south, west, north
  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_NORTH = 2'd3
  } dir_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_FETCH,
    S_PROBE,
    S_CHECK,
    S_DONE,
    S_QREPLY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_wr;     // write wall bit of input cell
    logic run_start;   // latch source, reset sweep and queue pointers
    logic clear_step;  // clear one distance entry
    logic seed;        // mark source and push it
    logic pop_rd;      // read queue at head
    logic cur_load;    // capture popped cell
    logic probe_rd;    // read wall and distance at neighbor
    logic visit;       // mark neighbor and push it if free
    logic dir_next;    // advance neighbor direction
    logic query_rd;    // read distance at input cell
    logic query_out;   // present query word
    logic done_out;    // present run done word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep at last entry
    logic src_in;      // source inside configured area
    logic q_empty;     // frontier queue empty
    logic nbr_in;      // current neighbor inside configured area
    logic dir_last;    // current direction is the last one
  } stat_t;

endpackage

@@ rtl/core/gbd_ctrl.sv @@
// Controller state machine for the grid breadth-first distance unit.
// Depends on gbd_pkg (state, command and status types).
module gbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  input  gbd_pkg::stat_t    stat,
  output logic              busy,
  output gbd_pkg::cmd_t     cmd
);

  gbd_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbd_pkg::S_IDLE: begin
        if (start) begin
          if (kind == gbd_pkg::KIND_RUN) state_next = gbd_pkg::S_CLEAR;
          else if (kind == gbd_pkg::KIND_QUERY) state_next = gbd_pkg::S_QREPLY;
        end
      end
      gbd_pkg::S_CLEAR: begin
        if (stat.clear_last) begin
          state_next = stat.src_in ? gbd_pkg::S_SEED : gbd_pkg::S_DONE;
        end
      end
      gbd_pkg::S_SEED:  state_next = gbd_pkg::S_POP;
      gbd_pkg::S_POP:   state_next = stat.q_empty ? gbd_pkg::S_DONE : gbd_pkg::S_FETCH;
      gbd_pkg::S_FETCH: state_next = gbd_pkg::S_PROBE;
      gbd_pkg::S_PROBE: begin
        if (stat.nbr_in) state_next = gbd_pkg::S_CHECK;
        else if (stat.dir_last) state_next = gbd_pkg::S_POP;
      end
      gbd_pkg::S_CHECK: begin
        state_next = stat.dir_last ? gbd_pkg::S_POP : gbd_pkg::S_PROBE;
      end
      gbd_pkg::S_DONE:   state_next = gbd_pkg::S_IDLE;
      gbd_pkg::S_QREPLY: state_next = gbd_pkg::S_IDLE;
      default:           state_next = gbd_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state != gbd_pkg::S_IDLE);
    unique case (state)
      gbd_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_wr   = (kind == gbd_pkg::KIND_LOAD);
          cmd.run_start = (kind == gbd_pkg::KIND_RUN);
          cmd.query_rd  = (kind == gbd_pkg::KIND_QUERY);
        end
      end
      gbd_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      gbd_pkg::S_SEED:  cmd.seed = 1'b1;
      gbd_pkg::S_POP:   cmd.pop_rd = !stat.q_empty;
      gbd_pkg::S_FETCH: cmd.cur_load = 1'b1;
      gbd_pkg::S_PROBE: begin
        cmd.probe_rd = stat.nbr_in;
        cmd.dir_next = !stat.nbr_in && !stat.dir_last;
      end
      gbd_pkg::S_CHECK: begin
        cmd.visit    = 1'b1;
        cmd.dir_next = !stat.dir_last;
      end
      gbd_pkg::S_DONE:   cmd.done_out = 1'b1;
      gbd_pkg::S_QREPLY: cmd.query_out = 1'b1;
      default: ;
    endcase
  end

  // A check always follows the probe that issued its reads
  a_check_after_probe: assert property (@(posedge clk) disable iff (rst)
    state == gbd_pkg::S_CHECK |-> $past(state) == gbd_pkg::S_PROBE)
    else $error("check state not preceded by probe");

  // Clearing ends only toward seed or done
  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (state == gbd_pkg::S_CLEAR && stat.clear_last) |=>
      (state == gbd_pkg::S_SEED || state == gbd_pkg::S_DONE))
    else $error("clear sweep left to a wrong state");

  // Load and unused-kind words are taken without leaving idle; a run word is not
  a_busy_after_run: assert property (@(posedge clk) disable iff (rst)
    cmd.run_start |=> busy)
    else $error("run accepted but unit not busy");

endmodule

@@ rtl/core/gbd_datapath.sv @@
// Datapath of the grid breadth-first distance unit: wall map, distance store,
// frontier queue, config registers and result registers. Depends on gbd_pkg.
module gbd_datapath #(
  parameter int MAX_ROWS = gbd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gbd_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gbd_pkg::cmd_t                    cmd,
  output gbd_pkg::stat_t                   stat,
  input  logic [5:0]                       row,
  input  logic [5:0]                       col,
  input  logic                             wall,
  input  logic                             cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0]        cfg_data,
  output logic                             strobe,
  output logic [gbd_pkg::DIST_W-1:0]       distance,
  output logic                             reachable,
  output logic                             run_done
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = RW + CW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DW     = gbd_pkg::DIST_W;
  localparam int QW     = DW + ADDR_W;
  localparam int RCMP_W = (RW + 1 > gbd_pkg::CFG_W) ? RW + 1 : gbd_pkg::CFG_W;
  localparam int CCMP_W = (CW + 1 > gbd_pkg::CFG_W) ? CW + 1 : gbd_pkg::CFG_W;
  localparam logic [RCMP_W-1:0] MAX_R = RCMP_W'(MAX_ROWS);
  localparam logic [CCMP_W-1:0] MAX_C = CCMP_W'(MAX_COLS);

  // Storage
  logic            wall_mem  [DEPTH];
  logic [DW:0]     dist_mem  [DEPTH];
  logic [QW-1:0]   queue_mem [DEPTH];

  logic [gbd_pkg::CFG_W-1:0] rows_cfg, cols_cfg;
  logic [5:0]        src_r, src_c;
  logic [ADDR_W-1:0] sweep;
  logic [ADDR_W:0]   head, tail;
  logic [RW-1:0]     cur_r;
  logic [CW-1:0]     cur_c;
  logic [DW-1:0]     cur_d;
  gbd_pkg::dir_t     dir;
  logic              q_in;
  logic              ran;
  logic              wall_q;
  logic [DW:0]       dist_q;
  logic [QW-1:0]     queue_q;

  logic [RCMP_W-1:0] eff_r;
  logic [CCMP_W-1:0] eff_c;
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr, src_addr, nbr_addr, dist_rd_addr;
  logic [RW:0]       nr_ext;
  logic [CW:0]       nc_ext;
  logic [DW-1:0]     next_d;
  logic              push;
  logic              dist_we;
  logic [ADDR_W-1:0] dist_wr_addr;
  logic [DW:0]       dist_wr_data;
  logic              query_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= gbd_pkg::ROWS_RST;
      cols_cfg <= gbd_pkg::COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbd_pkg::REG_ROWS: rows_cfg <= cfg_data;
        gbd_pkg::REG_COLS: cols_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective area, capped at the store size
  always_comb begin
    eff_r = (RCMP_W'(rows_cfg) > MAX_R) ? MAX_R : RCMP_W'(rows_cfg);
    eff_c = (CCMP_W'(cols_cfg) > MAX_C) ? MAX_C : CCMP_W'(cols_cfg);
  end

  // Input cell and source addresses
  assign in_inside = (RCMP_W'(row) < MAX_R) && (CCMP_W'(col) < MAX_C);
  assign in_addr   = {RW'(row), CW'(col)};
  assign src_addr  = {RW'(src_r), CW'(src_c)};

  // Neighbor coordinates; one extra bit so a step off either edge fails the compare
  always_comb begin
    nr_ext = {1'b0, cur_r};
    nc_ext = {1'b0, cur_c};
    case (dir)
      gbd_pkg::DIR_EAST:  nc_ext = {1'b0, cur_c} + 1'b1;
      gbd_pkg::DIR_SOUTH: nr_ext = {1'b0, cur_r} + 1'b1;
      gbd_pkg::DIR_WEST:  nc_ext = {1'b0, cur_c} - 1'b1;
      gbd_pkg::DIR_NORTH: nr_ext = {1'b0, cur_r} - 1'b1;
      default: ;
    endcase
  end
  assign nbr_addr = {nr_ext[RW-1:0], nc_ext[CW-1:0]};

  // Status to controller
  always_comb begin
    stat.clear_last = (sweep == {ADDR_W{1'b1}});
    stat.src_in     = (RCMP_W'(src_r) < eff_r) && (CCMP_W'(src_c) < eff_c);
    stat.q_empty    = (head == tail);
    stat.nbr_in     = (RCMP_W'(nr_ext) < eff_r) && (CCMP_W'(nc_ext) < eff_c);
    stat.dir_last   = (dir == gbd_pkg::DIR_NORTH);
  end

  // Run control registers: source, sweep, queue pointers, current cell
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      ran  <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        head <= '0;
        tail <= '0;
        ran  <= 1'b1;
      end
      if (cmd.pop_rd) head <= head + 1'b1;
      if (cmd.seed || push) tail <= tail + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      src_r <= row;
      src_c <= col;
      sweep <= '0;
    end
    if (cmd.clear_step) sweep <= sweep + 1'b1;
    if (cmd.cur_load) begin
      cur_d <= queue_q[QW-1:ADDR_W];
      cur_r <= queue_q[ADDR_W-1:CW];
      cur_c <= queue_q[CW-1:0];
      dir   <= gbd_pkg::DIR_EAST;
    end else if (cmd.dir_next) begin
      dir <= gbd_pkg::dir_t'(dir + 2'd1);
    end
    if (cmd.query_rd) q_in <= in_inside;
  end

  // Neighbor is taken when free of wall and not yet reached
  assign next_d = (cur_d == {DW{1'b1}}) ? cur_d : cur_d + 1'b1;
  assign push   = cmd.visit && !wall_q && !dist_q[DW];

  // Wall map
  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_inside) wall_mem[in_addr] <= wall;
    if (cmd.probe_rd) wall_q <= wall_mem[nbr_addr];
  end

  // Distance store write port select
  always_comb begin
    dist_we      = 1'b0;
    dist_wr_addr = nbr_addr;
    dist_wr_data = {1'b1, next_d};
    if (cmd.clear_step) begin
      dist_we      = 1'b1;
      dist_wr_addr = sweep;
      dist_wr_data = '0;
    end else if (cmd.seed) begin
      dist_we      = 1'b1;
      dist_wr_addr = src_addr;
      dist_wr_data = {1'b1, {DW{1'b0}}};
    end else if (push) begin
      dist_we = 1'b1;
    end
  end
  assign dist_rd_addr = cmd.query_rd ? in_addr : nbr_addr;

  // Distance store
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wr_addr] <= dist_wr_data;
    if (cmd.probe_rd || cmd.query_rd) dist_q <= dist_mem[dist_rd_addr];
  end

  // Frontier queue
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      queue_mem[tail[ADDR_W-1:0]] <= {{DW{1'b0}}, src_addr};
    end else if (push) begin
      queue_mem[tail[ADDR_W-1:0]] <= {next_d, nbr_addr};
    end
    if (cmd.pop_rd) queue_q <= queue_mem[head[ADDR_W-1:0]];
  end

  // Result word registers
  assign query_ok = q_in && ran && dist_q[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.query_out || cmd.done_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_out) begin
      distance  <= query_ok ? dist_q[DW-1:0] : '0;
      reachable <= query_ok;
      run_done  <= 1'b0;
    end else if (cmd.done_out) begin
      distance  <= '0;
      reachable <= 1'b0;
      run_done  <= 1'b1;
    end
  end

  // Queue head never passes tail
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("frontier queue head passed tail");

  // A cell is pushed only from inside the configured area
  a_push_inside: assert property (@(posedge clk) disable iff (rst)
    push |-> stat.nbr_in)
    else $error("push of a neighbor outside the area");

  // Run end gives a done word on the next cycle
  a_done_word: assert property (@(posedge clk) disable iff (rst)
    cmd.done_out |=> (strobe && run_done && !reachable))
    else $error("done word missing after run end");

endmodule

@@ rtl/core/grid_bfs_distance_unit.sv @@
// Top level of the grid breadth-first distance unit (Lee maze flood).
// Instantiates gbd_ctrl and gbd_datapath; depends on gbd_pkg.
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+---------------------------
//  command   | kind, row, col, wall                  | start high, busy low
//  config    | cfg_index, cfg_data                   | cfg_we high, no wait
//  result    | distance, reachable, run_done         | strobe, one cycle
//
// A load gives no word and does not leave idle. A query passes through the reply
// state; its word is registered from the distance read. A run first clears the
// distance store, one entry a cycle (all 2**(RW+CW) entries, 4096 at 64 by 64),
// then for each reached cell pops the queue (pop and fetch states) and probes
// each neighbor in turn, checking in-area ones in the check state. Reset is
// synchronous; the result side cannot stall, words are never held.
module grid_bfs_distance_unit #(
  parameter int MAX_ROWS = gbd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gbd_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind,
  input  logic [5:0]                     row,
  input  logic [5:0]                     col,
  input  logic                           wall,
  input  logic                           cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0]      cfg_data,
  output logic                           strobe,
  output logic [gbd_pkg::DIST_W-1:0]     distance,
  output logic                           reachable,
  output logic                           run_done
);

  gbd_pkg::cmd_t  cmd;
  gbd_pkg::stat_t stat;

  gbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  gbd_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .row       (row),
    .col       (col),
    .wall      (wall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .distance  (distance),
    .reachable (reachable),
    .run_done  (run_done)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for grid_bfs_distance_unit: a directed table, random phases over many
// grid sizes and a serpentine maze, checked by an in-bench flood predictor or fixed words.
// Depends on gbd_pkg and the unit's RTL.
module tb_top;
  import gbd_pkg::*;

  localparam int NROWS = MAX_ROWS_DEF;
  localparam int NCOLS = MAX_COLS_DEF;
  localparam int CELLS = NROWS * NCOLS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_PCT = 23;
  localparam int TAIL_CYCLES = 8;
  localparam int DRAIN_LIMIT = 400_000;
  // limit sits far above the slowest legal run
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int N_PHASES = 20;
  localparam int SERP_COLS = 4;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              run_done;
  } word_t;

  typedef enum logic { STEP_WORD, STEP_CFG } step_op_t;

  typedef struct {
    step_op_t         op;
    logic [1:0]       kind;
    logic [5:0]       row;
    logic [5:0]       col;
    logic             wall;
    logic             fixed;
    word_t            want;
    reg_idx_t         idx;
    logic [CFG_W-1:0] val;
  } step_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        kind;
  logic [5:0]        row;
  logic [5:0]        col;
  logic              wall;
  logic              cfg_we;
  reg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              strobe;
  logic [DIST_W-1:0] distance;
  logic              reachable;
  logic              run_done;

  // Predictor state
  logic              wall_bits [CELLS];
  bit                wall_set  [CELLS];
  logic              hit_bits  [CELLS];
  logic [DIST_W-1:0] dist_mem  [CELLS];
  int unsigned       front_q   [CELLS];
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;

  word_t  due_words [$];
  step_t  dir_tab [$];
  int     errors;
  int     n_reports;
  int     n_words;
  int     n_runs;
  int     n_queries;
  int     n_checked;
  longint cycle_count = 0;
  bit     idle_on;

  grid_bfs_distance_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .wall      (wall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .distance  (distance),
    .reachable (reachable),
    .run_done  (run_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, due_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    if (n_reports < MAX_REPORTS) $display("ERROR: %s", msg);
    n_reports++;
    errors++;
  endfunction

  // effective size: register capped at the store dimension
  function automatic int unsigned span(input logic [CFG_W-1:0] v, input int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  // Breadth-first flood over the configured area
  function automatic void flood_from(input int unsigned sr, input int unsigned sc);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned head;
    int unsigned tail;
    int unsigned cur;
    int unsigned nb;
    int          nr;
    int          nc;
    nrows = span(rows_reg, NROWS);
    ncols = span(cols_reg, NCOLS);
    for (int i = 0; i < CELLS; i++) begin
      hit_bits[i] = 1'b0;
      dist_mem[i] = '0;
    end
    head = 0;
    tail = 0;
    if (sr >= nrows || sc >= ncols) return;
    cur = sr * NCOLS + sc;
    hit_bits[cur] = 1'b1;
    front_q[tail] = cur;
    tail++;
    while (head < tail) begin
      cur = front_q[head];
      head++;
      for (int k = 0; k < 4; k++) begin
        nr = int'(cur / NCOLS);
        nc = int'(cur % NCOLS);
        case (dir_t'(k))
          DIR_EAST:  nc = nc + 1;
          DIR_SOUTH: nr = nr + 1;
          DIR_WEST:  nc = nc - 1;
          DIR_NORTH: nr = nr - 1;
        endcase
        if (nr < 0 || nc < 0 || nr >= int'(nrows) || nc >= int'(ncols)) continue;
        nb = nr * NCOLS + nc;
        if (wall_bits[nb] === 1'b1 || hit_bits[nb]) continue;
        hit_bits[nb] = 1'b1;
        // saturate long paths
        dist_mem[nb] = (dist_mem[cur] == '1) ? dist_mem[cur] : dist_mem[cur] + 1'b1;
        front_q[tail] = nb;
        tail++;
      end
    end
  endfunction

  function automatic word_t answer_query(input logic [5:0] r, input logic [5:0] c);
    word_t       w;
    int unsigned i;
    i = r * NCOLS + c;
    w.reachable = hit_bits[i];
    w.distance = hit_bits[i] ? dist_mem[i] : '0;
    w.run_done = 1'b0;
    return w;
  endfunction

  // Update predictor for one accepted word; returns 1 when a result word follows
  function automatic bit predict_word(input logic [1:0] k, input logic [5:0] r,
                                      input logic [5:0] c, input logic w, output word_t res);
    int unsigned i;
    i = r * NCOLS + c;
    res = '0;
    case (k)
      KIND_LOAD: begin
        wall_bits[i] = w;
        wall_set[i] = 1'b1;
        return 1'b0;
      end
      KIND_RUN: begin
        flood_from(r, c);
        res.run_done = 1'b1;
        return 1'b1;
      end
      KIND_QUERY: begin
        res = answer_query(r, c);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one command word, with random idle before it, and wait for accept
  task automatic send_word(input logic [1:0] k, input logic [5:0] r, input logic [5:0] c,
                           input logic w, input bit fixed = 1'b0, input word_t want = '0);
    word_t res;
    bit    gives;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    row <= r;
    col <= c;
    wall <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    gives = predict_word(k, r, c, w, res);
    if (gives) due_words.push_back(fixed ? want : res);
    n_words++;
    if (k == KIND_RUN) n_runs++;
    if (k == KIND_QUERY) n_queries++;
  endtask

  // Stop sending and wait until every due word has come and the unit is idle
  task automatic settle();
    int waited;
    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while ((due_words.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_words.size() != 0) begin
      note_error($sformatf("%0d result words never arrived", due_words.size()));
      errors += due_words.size() - 1;
      due_words.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROWS) rows_reg = v;
    else cols_reg = v;
  endtask

  // A flood must never see a wall entry that was never loaded
  task automatic fill_area();
    int unsigned nr;
    int unsigned nc;
    nr = span(rows_reg, NROWS);
    nc = span(cols_reg, NCOLS);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!wall_set[r * NCOLS + c])
          send_word(KIND_LOAD, 6'(r), 6'(c), $urandom_range(99) < 25);
  endtask

  function automatic logic [5:0] pick_coord(input int unsigned lim, input bit in_area);
    if (in_area && lim > 0) return 6'($urandom_range(0, lim - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic step_t word_step(input logic [1:0] k, input logic [5:0] r,
                                      input logic [5:0] c, input logic w);
    step_t s;
    s.op = STEP_WORD;
    s.kind = k;
    s.row = r;
    s.col = c;
    s.wall = w;
    s.fixed = 1'b0;
    s.want = '0;
    s.idx = REG_ROWS;
    s.val = '0;
    return s;
  endfunction

  function automatic step_t typed_step(input logic [1:0] k, input logic [5:0] r,
                                       input logic [5:0] c, input word_t want);
    step_t s;
    s = word_step(k, r, c, 1'b0);
    s.fixed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_t cfg_step(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    step_t s;
    s = word_step(KIND_LOAD, '0, '0, 1'b0);
    s.op = STEP_CFG;
    s.idx = idx;
    s.val = v;
    return s;
  endfunction

  // One random phase: new grid size, then a run and a mix of words
  task automatic random_phase(input int ph);
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] cv;
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      roll;
    int unsigned      n_items;
    bit               big;
    settle();
    // capped registers use a narrow other side to keep the wall fill short
    if (ph == 3) begin
      rv = 7'd127;
      cv = 7'($urandom_range(1, 2));
    end else if (ph == 13) begin
      rv = 7'($urandom_range(1, 2));
      cv = 7'($urandom_range(64, 127));
    end else if (ph == 16) begin
      rv = 7'($urandom_range(65, 127));
      cv = 7'd1;
    end else if (ph % 13 == 5) begin
      rv = (ph == 18) ? 7'($urandom_range(1, 12)) : '0;
      cv = (ph == 18) ? '0 : 7'($urandom_range(1, 12));
    end else if (ph % 7 == 6) begin
      rv = 7'd1;
      cv = 7'($urandom_range(1, 64));
    end else begin
      rv = 7'($urandom_range(1, 12));
      cv = 7'($urandom_range(1, 12));
    end
    write_reg(REG_ROWS, rv);
    write_reg(REG_COLS, cv);
    fill_area();
    nr = span(rv, NROWS);
    nc = span(cv, NCOLS);
    big = nr * nc > 1024;
    send_word(KIND_RUN, pick_coord(nr, 1'b1), pick_coord(nc, 1'b1), 1'($urandom_range(0, 1)));
    n_items = $urandom_range(15, 35);
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 5 && !big) begin
        send_word(KIND_RUN, pick_coord(nr, roll != 0), pick_coord(nc, roll != 0),
                  1'($urandom_range(0, 1)));
      end else if (roll < 50) begin
        send_word(KIND_QUERY, pick_coord(nr, roll < 42), pick_coord(nc, roll < 42),
                  1'($urandom_range(0, 1)));
      end else if (roll < 92) begin
        send_word(KIND_LOAD, pick_coord(nr, roll < 80), pick_coord(nc, roll < 80),
                  $urandom_range(99) < 30);
      end else begin
        // unused kind, ignored by the unit
        send_word(KIND_UNUSED, pick_coord(0, 1'b0), pick_coord(0, 1'b0),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    word_t want;
    if (!rst && strobe) begin
      if (due_words.size() == 0) begin
        note_error($sformatf("unexpected word dist=%0d reach=%0b done=%0b",
                             distance, reachable, run_done));
      end else begin
        want = due_words.pop_front();
        n_checked++;
        if (distance !== want.distance || reachable !== want.reachable ||
            run_done !== want.run_done)
          note_error($sformatf("word %0d: dist exp %0d got %0d, reach exp %0b got %0b, done exp %0b got %0b",
                               n_checked, want.distance, distance, want.reachable, reachable,
                               want.run_done, run_done));
      end
    end
  end

  initial begin
    start = 1'b0;
    kind = KIND_LOAD;
    row = '0;
    col = '0;
    wall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data = '0;
    rst = 1'b1;
    rows_reg = ROWS_RST;
    cols_reg = COLS_RST;
    idle_on = 1'b1;
    errors = 0;
    n_reports = 0;
    n_words = 0;
    n_runs = 0;
    n_queries = 0;
    n_checked = 0;
    for (int i = 0; i < CELLS; i++) begin
      hit_bits[i] = 1'b0;
      dist_mem[i] = '0;
      wall_set[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reset state, a 2 by 3 grid with one wall, edge sources, empty area
    dir_tab.push_back(typed_step(KIND_QUERY, 6'd0, 6'd0, '{12'd0, 1'b0, 1'b0}));
    dir_tab.push_back(typed_step(KIND_QUERY, 6'd63, 6'd63, '{12'd0, 1'b0, 1'b0}));
    dir_tab.push_back(word_step(KIND_UNUSED, 6'd63, 6'd63, 1'b1));
    dir_tab.push_back(cfg_step(REG_ROWS, 7'd2));
    dir_tab.push_back(cfg_step(REG_COLS, 7'd3));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd0, 6'd0, 1'b0));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd0, 6'd1, 1'b1));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd0, 6'd2, 1'b0));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd1, 6'd0, 1'b0));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd1, 6'd1, 1'b0));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd1, 6'd2, 1'b0));
    dir_tab.push_back(word_step(KIND_LOAD, 6'd63, 6'd63, 1'b1));
    dir_tab.push_back(typed_step(KIND_RUN, 6'd0, 6'd0, '{12'd0, 1'b0, 1'b1}));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd1, 6'd2, 1'b0));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd0, 6'd2, 1'b1));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd0, 6'd1, 1'b0));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd63, 6'd63, 1'b0));
    // source on a wall
    dir_tab.push_back(typed_step(KIND_RUN, 6'd0, 6'd1, '{12'd0, 1'b0, 1'b1}));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd0, 6'd1, 1'b0));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd1, 6'd1, 1'b0));
    // source outside the area
    dir_tab.push_back(typed_step(KIND_RUN, 6'd5, 6'd0, '{12'd0, 1'b0, 1'b1}));
    dir_tab.push_back(word_step(KIND_QUERY, 6'd0, 6'd0, 1'b0));
    // zero rows leaves no cell in use
    dir_tab.push_back(cfg_step(REG_ROWS, 7'd0));
    dir_tab.push_back(typed_step(KIND_RUN, 6'd0, 6'd0, '{12'd0, 1'b0, 1'b1}));
    dir_tab.push_back(typed_step(KIND_QUERY, 6'd0, 6'd0, '{12'd0, 1'b0, 1'b0}));
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == STEP_CFG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].wall,
                  dir_tab[i].fixed, dir_tab[i].want);
      end
    end

    // Random phases; a middle stretch runs without idle gaps
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_on = !(ph >= 8 && ph < 14);
      random_phase(ph);
    end
    idle_on = 1'b1;

    // Serpentine maze down all rows of a narrow strip for long paths
    settle();
    write_reg(REG_ROWS, 7'd64);
    write_reg(REG_COLS, 7'(SERP_COLS));
    for (int r = 0; r < NROWS; r++)
      for (int c = 0; c < SERP_COLS; c++)
        send_word(KIND_LOAD, 6'(r), 6'(c),
                  r % 2 == 1 && c != ((r % 4 == 1) ? SERP_COLS - 1 : 0));
    send_word(KIND_RUN, 6'd0, 6'd0, 1'b0);
    send_word(KIND_QUERY, 6'd62, 6'd0, 1'b0);
    send_word(KIND_QUERY, 6'd63, 6'd0, 1'b1);
    repeat (30)
      send_word(KIND_QUERY, 6'($urandom_range(0, 63)), 6'($urandom_range(0, SERP_COLS - 1)),
                1'($urandom_range(0, 1)));

    settle();
    $display("sent %0d words (%0d runs, %0d queries), checked %0d result words, %0d errors",
             n_words, n_runs, n_queries, n_checked, errors);
    $display("grid sizes 0 to 127 per register, walls, edge sources and a serpentine maze");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
